// ===== hdl/tti_pkg.sv =====
package tti_pkg;

  localparam int TableEntriesDefault = 160;
  localparam int RomSlots = 256;
  // Number of slots that hold calibration codes; the rest read as zero.
  localparam int TableFilled = 160;

  localparam logic [1:0] StatusValid = 2'd0;
  localparam logic [1:0] StatusBelow = 2'd1;
  localparam logic [1:0] StatusAbove = 2'd2;

  // Fixed calibration table; entry i stands for -20 + i degrees.
  // Slots from entry TableFilled upwards hold zero.
  function automatic logic [15:0] rom_entry(input logic [7:0] idx);
    logic [15:0] v;
    case (idx)
      8'd0: v = 16'h653E; 8'd1: v = 16'h65E4; 8'd2: v = 16'h668A; 8'd3: v = 16'h6730;
      8'd4: v = 16'h67D6; 8'd5: v = 16'h687C; 8'd6: v = 16'h6923; 8'd7: v = 16'h69C9;
      8'd8: v = 16'h6A70; 8'd9: v = 16'h6B17; 8'd10: v = 16'h6BBD; 8'd11: v = 16'h6C64;
      8'd12: v = 16'h6D0B; 8'd13: v = 16'h6DB1; 8'd14: v = 16'h6E58; 8'd15: v = 16'h6EFF;
      8'd16: v = 16'h6FA6; 8'd17: v = 16'h704C; 8'd18: v = 16'h70F3; 8'd19: v = 16'h719A;
      8'd20: v = 16'h7241; 8'd21: v = 16'h72E7; 8'd22: v = 16'h738E; 8'd23: v = 16'h7434;
      8'd24: v = 16'h74DB; 8'd25: v = 16'h7581; 8'd26: v = 16'h7628; 8'd27: v = 16'h76CE;
      8'd28: v = 16'h7774; 8'd29: v = 16'h781A; 8'd30: v = 16'h78C0; 8'd31: v = 16'h7966;
      8'd32: v = 16'h7A0C; 8'd33: v = 16'h7AB2; 8'd34: v = 16'h7B57; 8'd35: v = 16'h7BFD;
      8'd36: v = 16'h7CA2; 8'd37: v = 16'h7D47; 8'd38: v = 16'h7DEC; 8'd39: v = 16'h7E91;
      8'd40: v = 16'h7F36; 8'd41: v = 16'h7FDA; 8'd42: v = 16'h807E; 8'd43: v = 16'h8123;
      8'd44: v = 16'h81C6; 8'd45: v = 16'h826A; 8'd46: v = 16'h830E; 8'd47: v = 16'h83B1;
      8'd48: v = 16'h8454; 8'd49: v = 16'h84F7; 8'd50: v = 16'h859A; 8'd51: v = 16'h863D;
      8'd52: v = 16'h86DF; 8'd53: v = 16'h8781; 8'd54: v = 16'h8823; 8'd55: v = 16'h88C5;
      8'd56: v = 16'h8966; 8'd57: v = 16'h8A07; 8'd58: v = 16'h8AA8; 8'd59: v = 16'h8B49;
      8'd60: v = 16'h8BE9; 8'd61: v = 16'h8C89; 8'd62: v = 16'h8D29; 8'd63: v = 16'h8DC8;
      8'd64: v = 16'h8E68; 8'd65: v = 16'h8F07; 8'd66: v = 16'h8FA5; 8'd67: v = 16'h9044;
      8'd68: v = 16'h90E2; 8'd69: v = 16'h9180; 8'd70: v = 16'h921D; 8'd71: v = 16'h92BB;
      8'd72: v = 16'h9358; 8'd73: v = 16'h93F4; 8'd74: v = 16'h9491; 8'd75: v = 16'h952D;
      8'd76: v = 16'h95C8; 8'd77: v = 16'h9664; 8'd78: v = 16'h96FF; 8'd79: v = 16'h979A;
      8'd80: v = 16'h9834; 8'd81: v = 16'h98CE; 8'd82: v = 16'h9968; 8'd83: v = 16'h9A01;
      8'd84: v = 16'h9A9A; 8'd85: v = 16'h9B33; 8'd86: v = 16'h9BCB; 8'd87: v = 16'h9C63;
      8'd88: v = 16'h9CFB; 8'd89: v = 16'h9D92; 8'd90: v = 16'h9E29; 8'd91: v = 16'h9EC0;
      8'd92: v = 16'h9F56; 8'd93: v = 16'h9FEC; 8'd94: v = 16'hA082; 8'd95: v = 16'hA117;
      8'd96: v = 16'hA1AC; 8'd97: v = 16'hA240; 8'd98: v = 16'hA2D4; 8'd99: v = 16'hA368;
      8'd100: v = 16'hA3FB; 8'd101: v = 16'hA48E; 8'd102: v = 16'hA521; 8'd103: v = 16'hA5B3;
      8'd104: v = 16'hA645; 8'd105: v = 16'hA6D6; 8'd106: v = 16'hA767; 8'd107: v = 16'hA7F8;
      8'd108: v = 16'hA888; 8'd109: v = 16'hA918; 8'd110: v = 16'hA9A7; 8'd111: v = 16'hAA36;
      8'd112: v = 16'hAAC5; 8'd113: v = 16'hAB53; 8'd114: v = 16'hABE1; 8'd115: v = 16'hAC6F;
      8'd116: v = 16'hACFC; 8'd117: v = 16'hAD89; 8'd118: v = 16'hAE15; 8'd119: v = 16'hAEA1;
      8'd120: v = 16'hAF2C; 8'd121: v = 16'hAFB8; 8'd122: v = 16'hB042; 8'd123: v = 16'hB0CC;
      8'd124: v = 16'hB156; 8'd125: v = 16'hB1DE; 8'd126: v = 16'hB266; 8'd127: v = 16'hB2ED;
      8'd128: v = 16'hB373; 8'd129: v = 16'hB3F8; 8'd130: v = 16'hB47C; 8'd131: v = 16'hB4FF;
      8'd132: v = 16'hB580; 8'd133: v = 16'hB601; 8'd134: v = 16'hB680; 8'd135: v = 16'hB6FD;
      8'd136: v = 16'hB779; 8'd137: v = 16'hB7F3; 8'd138: v = 16'hB86C; 8'd139: v = 16'hB8E3;
      8'd140: v = 16'hB959; 8'd141: v = 16'hB9CD; 8'd142: v = 16'hBA3F; 8'd143: v = 16'hBAAF;
      8'd144: v = 16'hBB1D; 8'd145: v = 16'hBB89; 8'd146: v = 16'hBBF4; 8'd147: v = 16'hBC5C;
      8'd148: v = 16'hBCC2; 8'd149: v = 16'hBD26; 8'd150: v = 16'hBD88; 8'd151: v = 16'hBDE8;
      8'd152: v = 16'hBE45; 8'd153: v = 16'hBEA0; 8'd154: v = 16'hBEF9; 8'd155: v = 16'hBF4F;
      8'd156: v = 16'hBFA3; 8'd157: v = 16'hBFF5; 8'd158: v = 16'hC044; 8'd159: v = 16'hC090;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/thermistor_table_interpolator_top.sv =====
// Thermistor code to temperature converter.
// Input channel: in_valid / in_stall carries one unsigned 16-bit converter
// code (in_adc_code) per transfer. Output channel: out_valid / out_stall
// carries out_temperature_tenths (signed tenths of a degree) and
// out_range_status (0 valid, 1 below table, 2 above table, saturated).
// Every input transfer gives exactly one output transfer, in order.
// The work runs in a pipeline: one input register, 8 binary search stages
// (one table compare each), one stage that loads the bracketing entries,
// 4 restoring division stages (one quotient bit each, the fraction is
// 0..10) and the output register. A new code can be accepted every cycle
// while no result is held under out_stall, and up to 15 items are in flight.
// Synchronous reset (rst_n low) clears every valid bit; the table is constant.
// While a result waits under out_stall the whole pipeline holds and in_stall
// is high; the result stays unchanged on the outputs.
module thermistor_table_interpolator_top #(
  parameter int TABLE_ENTRIES = tti_pkg::TableEntriesDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_adc_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [11:0] out_temperature_tenths,
  output logic [1:0]         out_range_status
);

  localparam int N = (TABLE_ENTRIES < 2) ? 2 :
                     ((TABLE_ENTRIES > tti_pkg::RomSlots) ? tti_pkg::RomSlots : TABLE_ENTRIES);
  // Slots past the filled part read as zero, so the search stops there.
  localparam int SearchTop = (N > tti_pkg::TableFilled) ? tti_pkg::TableFilled : N;
  localparam int SatT = (N - 21) * 10;
  localparam logic signed [11:0] SatTemp =
    (SatT > 2047) ? 12'sd2047 : 12'(SatT);
  localparam int SearchSteps = 8;
  localparam int DivSteps = 4;

  logic        adv;

  // Search stages: the answer lies in lo..hi, hi = SearchTop means above range.
  logic [15:0] sr_code_r [0:SearchSteps];
  logic [7:0]  sr_lo_r   [0:SearchSteps];
  logic [7:0]  sr_hi_r   [0:SearchSteps];
  logic [SearchSteps:0] sr_vld_r;
  logic [7:0]  mid        [1:SearchSteps];
  logic [7:0]  sr_lo_nxt  [1:SearchSteps];
  logic [7:0]  sr_hi_nxt  [1:SearchSteps];

  // Load stage signals.
  logic [7:0]  ld_idx;
  logic [15:0] ld_ent_hi;
  logic [15:0] ld_ent_lo;
  logic        ld_above;
  logic        ld_below;
  logic        ld_span;
  logic signed [12:0] ld_base_wide;

  // Division stages.
  logic [19:0] dv_rem_r  [0:DivSteps];
  logic [15:0] dv_den_r  [0:DivSteps];
  logic [3:0]  dv_quo_r  [0:DivSteps];
  logic signed [11:0] dv_base_r [0:DivSteps];
  logic [1:0]  dv_stat_r [0:DivSteps];
  logic [DivSteps:0] dv_vld_r;
  logic [19:0] dv_sub     [1:DivSteps];
  logic [19:0] dv_rem_nxt [1:DivSteps];
  logic [3:0]  dv_quo_nxt [1:DivSteps];

  logic               out_valid_r;
  logic signed [11:0] out_temp_r;
  logic [1:0]         out_stat_r;

  // The pipeline moves whenever no result is held back at the output.
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  assign out_valid              = out_valid_r;
  assign out_temperature_tenths = out_temp_r;
  assign out_range_status       = out_stat_r;

  // One binary search step per stage.
  always_comb begin
    for (int k = 1; k <= SearchSteps; k++) begin
      mid[k]       = 8'((9'(sr_lo_r[k-1]) + 9'(sr_hi_r[k-1])) >> 1);
      sr_lo_nxt[k] = sr_lo_r[k-1];
      sr_hi_nxt[k] = sr_hi_r[k-1];
      if (sr_lo_r[k-1] != sr_hi_r[k-1]) begin
        if (tti_pkg::rom_entry(mid[k]) < sr_code_r[k-1]) begin
          sr_lo_nxt[k] = mid[k] + 8'd1;
        end else begin
          sr_hi_nxt[k] = mid[k];
        end
      end
    end
  end

  // Bracketing entries and the range decision for the found index.
  assign ld_idx       = sr_lo_r[SearchSteps];
  assign ld_ent_hi    = tti_pkg::rom_entry(ld_idx);
  assign ld_ent_lo    = tti_pkg::rom_entry(ld_idx - 8'd1);
  assign ld_above     = (ld_idx == 8'(SearchTop));
  assign ld_below     = (ld_idx == 8'd1);
  assign ld_span      = (ld_ent_hi > ld_ent_lo);
  assign ld_base_wide = ($signed({5'd0, ld_idx}) - 13'sd21) * 13'sd10;

  // One restoring division step per stage, quotient bits from the top.
  always_comb begin
    for (int k = 1; k <= DivSteps; k++) begin
      dv_sub[k] = {4'd0, dv_den_r[k-1]} << (DivSteps - k);
      if (dv_rem_r[k-1] >= dv_sub[k]) begin
        dv_rem_nxt[k] = dv_rem_r[k-1] - dv_sub[k];
        dv_quo_nxt[k] = {dv_quo_r[k-1][2:0], 1'b1};
      end else begin
        dv_rem_nxt[k] = dv_rem_r[k-1];
        dv_quo_nxt[k] = {dv_quo_r[k-1][2:0], 1'b0};
      end
    end
  end

  // Pipeline registers; valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_vld_r    <= '0;
      dv_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      sr_vld_r     <= {sr_vld_r[SearchSteps-1:0], in_valid};
      sr_code_r[0] <= in_adc_code;
      sr_lo_r[0]   <= 8'd1;
      sr_hi_r[0]   <= 8'(SearchTop);
      for (int k = 1; k <= SearchSteps; k++) begin
        sr_code_r[k] <= sr_code_r[k-1];
        sr_lo_r[k]   <= sr_lo_nxt[k];
        sr_hi_r[k]   <= sr_hi_nxt[k];
      end

      dv_vld_r    <= {dv_vld_r[DivSteps-1:0], sr_vld_r[SearchSteps]};
      dv_quo_r[0] <= 4'd0;
      if (ld_above) begin
        dv_base_r[0] <= SatTemp;
        dv_stat_r[0] <= tti_pkg::StatusAbove;
      end else if (ld_below) begin
        dv_base_r[0] <= 12'sd0;
        dv_stat_r[0] <= tti_pkg::StatusBelow;
      end else begin
        dv_base_r[0] <= ld_base_wide[11:0];
        dv_stat_r[0] <= tti_pkg::StatusValid;
      end
      // Out of range or a zero span gives a zero fraction.
      if (!ld_above && !ld_below && ld_span) begin
        dv_rem_r[0] <= {4'd0, sr_code_r[SearchSteps] - ld_ent_lo} * 20'd10;
        dv_den_r[0] <= ld_ent_hi - ld_ent_lo;
      end else begin
        dv_rem_r[0] <= 20'd0;
        dv_den_r[0] <= 16'hFFFF;
      end
      for (int k = 1; k <= DivSteps; k++) begin
        dv_rem_r[k]  <= dv_rem_nxt[k];
        dv_quo_r[k]  <= dv_quo_nxt[k];
        dv_den_r[k]  <= dv_den_r[k-1];
        dv_base_r[k] <= dv_base_r[k-1];
        dv_stat_r[k] <= dv_stat_r[k-1];
      end

      out_valid_r <= dv_vld_r[DivSteps];
      out_temp_r  <= dv_base_r[DivSteps] + $signed({8'd0, dv_quo_r[DivSteps]});
      out_stat_r  <= dv_stat_r[DivSteps];
    end
  end

endmodule
